/* hdl/csrp_pkg.sv */
// Shared types and constants of the cache set replacement block.
`default_nettype none

package csrp_pkg;

    localparam int WAY_BITS     = 4;
    localparam int NUM_WAYS     = 1 << WAY_BITS;
    localparam int TAG_BITS_DEF = 16;
    localparam int IN_TAG_W     = 16;
    localparam int EVICT_W      = 16;
    localparam int PV_W         = NUM_WAYS * WAY_BITS;
    localparam int OUT_DATA_W   = 24;
    localparam int OUT_PAD_W    = OUT_DATA_W - EVICT_W - WAY_BITS;
    localparam int CFG_IDX_W    = 2;

    localparam logic [PV_W-1:0]     PV_RESET     = 64'hB100_1501_2103_0100;
    localparam logic [WAY_BITS-1:0] INSERT_RESET = 4'd13;
    localparam logic [WAY_BITS-1:0] LAST_WAY     = WAY_BITS'(NUM_WAYS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE    = 2'd0,
        CFG_PROMOTE = 2'd1,
        CFG_INSERT  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                we;
        logic                wsel_rdata;
        logic [WAY_BITS-1:0] waddr;
        logic [WAY_BITS-1:0] raddr;
    } t_store_ctl;

    typedef struct packed {
        logic                upd;
        logic [WAY_BITS-1:0] way;
    } t_tree_ctl;

endpackage

`default_nettype wire

/* hdl/csrp_tag_store.sv */
// Tag register file of the set with one read port and one write port.
`default_nettype none

module csrp_tag_store #(
    parameter int TAG_BITS = csrp_pkg::TAG_BITS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire csrp_pkg::t_store_ctl i_ctl,
    input  wire  [TAG_BITS-1:0]      i_tag,
    output logic [TAG_BITS-1:0]      o_rdata
);
    import csrp_pkg::*;

    logic [TAG_BITS-1:0] r_tags [NUM_WAYS];

    assign o_rdata = r_tags[i_ctl.raddr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_WAYS; i++) begin
                r_tags[i] <= '0;
            end
        end else if (i_ctl.we) begin
            r_tags[i_ctl.waddr] <= i_ctl.wsel_rdata ? o_rdata : i_tag;
        end
    end

endmodule

`default_nettype wire

/* hdl/csrp_plru_tree.sv */
// Pseudo-LRU tree bits with victim walk and path update.
`default_nettype none

module csrp_plru_tree (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire csrp_pkg::t_tree_ctl       i_ctl,
    output logic [csrp_pkg::WAY_BITS-1:0]  o_victim
);
    import csrp_pkg::*;

    logic [NUM_WAYS-1:1] r_bits;
    logic [NUM_WAYS-1:1] n_bits;
    logic [WAY_BITS:0]   walk;
    logic [WAY_BITS:0]   node;

    always_comb begin
        walk = (WAY_BITS + 1)'(1);
        for (int k = 0; k < WAY_BITS; k++) begin
            walk = {walk[WAY_BITS-1:0], r_bits[walk[WAY_BITS-1:0]]};
        end
        o_victim = walk[WAY_BITS-1:0];
    end

    always_comb begin
        n_bits = r_bits;
        node   = {1'b1, i_ctl.way};
        for (int k = 0; k < WAY_BITS; k++) begin
            n_bits[node[WAY_BITS:1]] = ~node[0];
            node = {1'b0, node[WAY_BITS:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 1; n < NUM_WAYS; n++) begin
                r_bits[n] <= n[0];
            end
        end else if (i_ctl.upd) begin
            r_bits <= n_bits;
        end
    end

endmodule

`default_nettype wire

/* hdl/csrp_seq.sv */
// Sequencer that scans, shifts and updates the set one way per cycle.
`default_nettype none

module csrp_seq #(
    parameter int TAG_BITS = csrp_pkg::TAG_BITS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire  [csrp_pkg::IN_TAG_W-1:0]  i_in_tag,
    input  wire                            i_mode,
    input  wire  [csrp_pkg::PV_W-1:0]      i_promote,
    input  wire  [csrp_pkg::WAY_BITS-1:0]  i_insert,
    output csrp_pkg::t_store_ctl           o_store,
    output logic [TAG_BITS-1:0]            o_tag,
    input  wire  [TAG_BITS-1:0]            i_rdata,
    output csrp_pkg::t_tree_ctl            o_tree,
    input  wire  [csrp_pkg::WAY_BITS-1:0]  i_victim,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic                           o_out_hit,
    output logic [csrp_pkg::WAY_BITS-1:0]  o_out_way,
    output logic [csrp_pkg::EVICT_W-1:0]   o_out_evict
);
    import csrp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TREE,
        S_SHIFT,
        S_FINISH
    } t_state;

    t_state              r_state, n_state;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic [TAG_BITS-1:0] r_evict, n_evict;
    logic [WAY_BITS-1:0] r_idx, n_idx;
    logic [WAY_BITS-1:0] r_used, n_used;
    logic                r_hit, n_hit;
    logic                r_up, n_up;
    logic                r_out_valid, n_out_valid;
    logic                r_out_hit, n_out_hit;
    logic [WAY_BITS-1:0] r_out_way, n_out_way;
    logic [EVICT_W-1:0]  r_out_evict, n_out_evict;

    logic                match;
    logic [WAY_BITS-1:0] target;
    logic [WAY_BITS-1:0] nb;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_tag       = r_tag;
    assign o_out_valid = r_out_valid;
    assign o_out_hit   = r_out_hit;
    assign o_out_way   = r_out_way;
    assign o_out_evict = r_out_evict;

    assign match  = (i_rdata == r_tag);
    assign target = match ? i_promote[{r_idx, 2'b00} +: WAY_BITS] : i_insert;
    assign nb     = r_up ? r_idx + 1'b1 : r_idx - 1'b1;

    always_comb begin
        n_state     = r_state;
        n_tag       = r_tag;
        n_evict     = r_evict;
        n_idx       = r_idx;
        n_used      = r_used;
        n_hit       = r_hit;
        n_up        = r_up;
        n_out_valid = r_out_valid;
        n_out_hit   = r_out_hit;
        n_out_way   = r_out_way;
        n_out_evict = r_out_evict;
        o_store     = '0;
        o_store.raddr = r_idx;
        o_tree      = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_tag   = TAG_BITS'(i_in_tag);
                    n_idx   = '0;
                    n_evict = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (match || r_idx == LAST_WAY) begin
                    n_hit = match;
                    if (!match) begin
                        n_evict = i_rdata;
                    end
                    if (i_mode) begin
                        n_used  = r_idx;
                        n_state = S_TREE;
                    end else begin
                        n_used  = target;
                        n_up    = (target > r_idx);
                        n_state = S_SHIFT;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_TREE: begin
                o_store.raddr = i_victim;
                o_tree.upd    = 1'b1;
                o_tree.way    = r_hit ? r_used : i_victim;
                if (!r_hit) begin
                    n_evict       = i_rdata;
                    n_used        = i_victim;
                    o_store.we    = 1'b1;
                    o_store.waddr = i_victim;
                end
                n_state = S_FINISH;
            end
            S_SHIFT: begin
                o_store.we    = 1'b1;
                o_store.waddr = r_idx;
                if (r_idx == r_used) begin
                    n_state = S_FINISH;
                end else begin
                    o_store.raddr      = nb;
                    o_store.wsel_rdata = 1'b1;
                    n_idx              = nb;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_hit;
                    n_out_way   = r_used;
                    n_out_evict = EVICT_W'(r_evict);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_tag       <= n_tag;
        r_evict     <= n_evict;
        r_idx       <= n_idx;
        r_used      <= n_used;
        r_hit       <= n_hit;
        r_up        <= n_up;
        r_out_hit   <= n_out_hit;
        r_out_way   <= n_out_way;
        r_out_evict <= n_out_evict;
    end

endmodule

`default_nettype wire

/* hdl/cache_set_replacement_plru_ipv.sv */
// Top level of the 16-way cache set with tree pseudo-LRU and vector replacement.
`default_nettype none

// One access word carries a tag; the block answers with one result word giving hit,
// the way or stack position now holding the tag, and the evicted tag. Accesses are
// handled one at a time through a single tag read port: the lookup reads one way per
// cycle up to the first match, tree mode then updates the tree bits and, on a miss,
// writes the tag into the victim way, and vector mode moves one stack entry per cycle;
// the result then loads the output register, which waits while the previous result
// has not been taken. A finished result may wait in the output register while the
// next access is taken. Configuration is accepted in any cycle and should be written
// only while the block is idle.
module cache_set_replacement_plru_ipv #(
    parameter int TAG_BITS = csrp_pkg::TAG_BITS_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // access_tag[15:0]
    input  wire  [csrp_pkg::IN_TAG_W-1:0]    i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    // way_used[3:0], evicted_tag[19:4], zero padding[23:20]
    output logic [csrp_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // hit[0]
    output logic                             o_m_axis_tuser,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [csrp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [csrp_pkg::PV_W-1:0]        i_cfg_data
);
    import csrp_pkg::*;

    logic                r_mode;
    logic [PV_W-1:0]     r_promote;
    logic [WAY_BITS-1:0] r_insert;

    t_store_ctl          store_ctl;
    t_tree_ctl           tree_ctl;
    logic [TAG_BITS-1:0] cur_tag;
    logic [TAG_BITS-1:0] rdata;
    logic [WAY_BITS-1:0] victim;
    logic [WAY_BITS-1:0] out_way;
    logic [EVICT_W-1:0]  out_evict;

    assign o_cfg_ready    = 1'b1;
    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_evict, out_way};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_promote <= PV_RESET;
            r_insert  <= INSERT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MODE:    r_mode    <= i_cfg_data[0];
                CFG_PROMOTE: r_promote <= i_cfg_data;
                CFG_INSERT:  r_insert  <= i_cfg_data[WAY_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    csrp_seq #(
        .TAG_BITS (TAG_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_tag    (i_s_axis_tdata),
        .i_mode      (r_mode),
        .i_promote   (r_promote),
        .i_insert    (r_insert),
        .o_store     (store_ctl),
        .o_tag       (cur_tag),
        .i_rdata     (rdata),
        .o_tree      (tree_ctl),
        .i_victim    (victim),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_hit   (o_m_axis_tuser),
        .o_out_way   (out_way),
        .o_out_evict (out_evict)
    );

    csrp_tag_store #(
        .TAG_BITS (TAG_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (store_ctl),
        .i_tag   (cur_tag),
        .o_rdata (rdata)
    );

    csrp_plru_tree u_tree (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (tree_ctl),
        .o_victim (victim)
    );

endmodule

`default_nettype wire

/* hdl/csrp_checker.sv */
// Port-level checks of the cache set replacement block and their binding.
`default_nettype none

module csrp_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_s_axis_tvalid,
    input wire                              o_s_axis_tready,
    input wire                              o_m_axis_tvalid,
    input wire                              i_m_axis_tready,
    input wire [csrp_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input wire                              o_m_axis_tuser
);
    import csrp_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
        |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("Result word changed while stalled.");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("Access taken while the previous one was still in work.");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser
        |-> o_m_axis_tdata[EVICT_W+WAY_BITS-1:WAY_BITS] == '0)
        else $error("A hit reported an evicted tag.");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[OUT_DATA_W-1:EVICT_W+WAY_BITS] == '0)
        else $error("Result padding bits are not zero.");

endmodule

bind cache_set_replacement_plru_ipv csrp_checker u_csrp_checker (.*);

`default_nettype wire

/* tb/sv/tb_cache_set_replacement_plru_ipv.sv */
// Testbench for the 16-way cache set block with tree pseudo-LRU and vector replacement.
`timescale 1ns / 100ps

module tb_cache_set_replacement_plru_ipv;
    import csrp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 2'd3;
    localparam logic [PV_W-1:0] PV_ALL_ZERO  = 64'h0000_0000_0000_0000;
    localparam logic [PV_W-1:0] PV_ALL_LAST  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [PV_W-1:0] PV_IDENTITY  = 64'hFEDC_BA98_7654_3210;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 150;
    localparam int POOL_SIZE    = 24;

    typedef struct packed {
        logic                hit;
        logic [WAY_BITS-1:0] way;
        logic [EVICT_W-1:0]  evict;
    } t_access_result;

    typedef enum {ROW_ACCESS, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [PV_W-1:0]      val;
        bit                   chk;
        t_access_result       want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [IN_TAG_W-1:0]   s_data = '0;
    logic                  m_ready = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_MODE;
    logic [PV_W-1:0]       cfg_data = '0;

    wire                   o_s_axis_tready;
    wire                   o_m_axis_tvalid;
    wire [OUT_DATA_W-1:0]  o_m_axis_tdata;
    wire                   o_m_axis_tuser;
    wire                   o_cfg_ready;

    logic [EVICT_W-1:0]    set_tags [NUM_WAYS];
    logic                  plru_bits [NUM_WAYS];
    logic                  plru_mode;
    logic [PV_W-1:0]       promo_vec;
    logic [WAY_BITS-1:0]   ins_pos;

    t_access_result        pending_results [$];
    t_dir_row              dir_rows [$];
    logic [IN_TAG_W-1:0]   tag_pool [POOL_SIZE];
    int                    mismatch_count = 0;
    int                    idle_cycles = 0;
    int                    stall_left = 0;
    int                    next_stall;
    bit                    no_gaps = 1'b0;

    cache_set_replacement_plru_ipv DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_pause();
        return no_gaps ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic int plru_victim();
        int node;
        node = 1;
        while (node < NUM_WAYS)
            node = 2 * node + int'(plru_bits[node]);
        return node - NUM_WAYS;
    endfunction

    function automatic void plru_point_away(int way);
        int node;
        node = way + NUM_WAYS;
        while (node > 1) begin
            plru_bits[node >> 1] = (node % 2 == 1) ? 1'b0 : 1'b1;
            node = node >> 1;
        end
    endfunction

    function automatic void stack_move(logic [EVICT_W-1:0] tag, int from, int to);
        if (to <= from) begin
            for (int i = from; i > to; i--)
                set_tags[i] = set_tags[i-1];
        end else begin
            for (int i = from; i < to; i++)
                set_tags[i] = set_tags[i+1];
        end
        set_tags[to] = tag;
    endfunction

    function automatic t_access_result cache_set_access(logic [IN_TAG_W-1:0] tag);
        t_access_result r;
        int pos;
        int used;
        pos = NUM_WAYS;
        for (int i = NUM_WAYS - 1; i >= 0; i--)
            if (set_tags[i] == tag)
                pos = i;
        r.hit = (pos < NUM_WAYS);
        r.evict = '0;
        if (plru_mode) begin
            if (r.hit) begin
                used = pos;
            end else begin
                used = plru_victim();
                r.evict = set_tags[used];
                set_tags[used] = tag;
            end
            plru_point_away(used);
        end else begin
            if (r.hit) begin
                used = int'(promo_vec[WAY_BITS*pos +: WAY_BITS]);
                stack_move(tag, pos, used);
            end else begin
                used = int'(ins_pos);
                r.evict = set_tags[NUM_WAYS-1];
                stack_move(tag, NUM_WAYS - 1, used);
            end
        end
        r.way = WAY_BITS'(used);
        return r;
    endfunction

    function automatic void set_policy_reg(logic [CFG_IDX_W-1:0] idx, logic [PV_W-1:0] val);
        case (idx)
            CFG_MODE:    plru_mode = val[0];
            CFG_PROMOTE: promo_vec = val;
            CFG_INSERT:  ins_pos = val[WAY_BITS-1:0];
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    task automatic check_result();
        t_access_result want;
        if (pending_results.size() == 0) begin
            flag_mismatch("result word with nothing pending", 64'(o_m_axis_tdata), 64'(0));
        end else begin
            want = pending_results.pop_front();
            if (o_m_axis_tuser !== want.hit)
                flag_mismatch("hit", 64'(o_m_axis_tuser), 64'(want.hit));
            if (o_m_axis_tdata[WAY_BITS-1:0] !== want.way)
                flag_mismatch("way_used", 64'(o_m_axis_tdata[WAY_BITS-1:0]), 64'(want.way));
            if (o_m_axis_tdata[WAY_BITS +: EVICT_W] !== want.evict)
                flag_mismatch("evicted_tag", 64'(o_m_axis_tdata[WAY_BITS +: EVICT_W]),
                              64'(want.evict));
        end
    endtask

    task automatic send_access(logic [IN_TAG_W-1:0] tag, bit chk, t_access_result typed);
        t_access_result r;
        int gap;
        cfg_valid <= 1'b0;
        gap = draw_pause();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= tag;
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = cache_set_access(tag);
        pending_results.push_back(chk ? typed : r);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PV_W-1:0] val);
        s_valid <= 1'b0;
        if (pending_results.size() != 0) begin
            cfg_valid <= 1'b0;
            while (pending_results.size() != 0) @(posedge i_clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        set_policy_reg(idx, val);
    endtask

    task automatic add_access(logic [IN_TAG_W-1:0] tag);
        dir_rows.push_back('{ROW_ACCESS, CFG_MODE, PV_W'(tag), 1'b0, '0});
    endtask

    task automatic add_write(logic [CFG_IDX_W-1:0] idx, logic [PV_W-1:0] val);
        dir_rows.push_back('{ROW_WRITE, idx, val, 1'b0, '0});
    endtask

    function automatic logic [IN_TAG_W-1:0] pick_tag();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return tag_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (r < 97)
            return IN_TAG_W'($urandom);
        return '0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (m_ready && o_m_axis_tvalid) begin
            check_result();
            next_stall = draw_pause();
            if (next_stall != 0) begin
                m_ready <= 1'b0;
                stall_left <= next_stall;
            end
        end else if (!m_ready) begin
            if (stall_left <= 1)
                m_ready <= 1'b1;
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (m_ready && o_m_axis_tvalid)
                || (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int item;
        logic [PV_W-1:0] pv;
        logic [WAY_BITS-1:0] ins;

        for (int i = 0; i < NUM_WAYS; i++) begin
            set_tags[i] = '0;
            plru_bits[i] = i[0];
        end
        plru_mode = 1'b0;
        promo_vec = PV_RESET;
        ins_pos = INSERT_RESET;

        // Right after reset the stack is empty and insertion goes to position 13.
        dir_rows.push_back('{ROW_ACCESS, CFG_MODE, 64'hFFFF, 1'b1, '{1'b0, 4'd13, 16'h0000}});
        // Tag zero matches the first empty way.
        dir_rows.push_back('{ROW_ACCESS, CFG_MODE, 64'h0000, 1'b1, '{1'b1, 4'd0, 16'h0000}});
        add_access(16'hFFFF);
        add_access(16'h0001);
        add_access(16'h8000);
        add_access(16'h5555);
        add_access(16'hAAAA);
        add_write(CFG_PROMOTE, PV_ALL_LAST);
        add_access(16'h0001);
        add_access(16'h8000);
        add_write(CFG_PROMOTE, PV_IDENTITY);
        add_access(16'h5555);
        add_write(CFG_INSERT, 64'd0);
        add_access(16'h1234);
        add_write(CFG_INSERT, 64'd15);
        add_access(16'h4321);
        add_write(CFG_IDX_NONE, PV_ALL_LAST);
        add_access(16'h00FF);
        add_write(CFG_MODE, 64'd1);
        add_access(16'hFFFF);
        add_access(16'h0F0F);
        add_access(16'hF0F0);
        add_access(16'h0000);
        add_access(16'h1234);
        add_access(16'hAAAA);
        add_write(CFG_PROMOTE, PV_ALL_ZERO);
        add_write(CFG_MODE, 64'd0);
        add_access(16'hAAAA);
        add_access(16'h5555);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[n]) begin
            if (dir_rows[n].kind == ROW_WRITE)
                write_reg(dir_rows[n].idx, dir_rows[n].val);
            else
                send_access(dir_rows[n].val[IN_TAG_W-1:0], dir_rows[n].chk, dir_rows[n].want);
        end

        item = 0;
        for (int p = 0; p < PHASES; p++) begin
            case ($urandom_range(0, 4))
                0: pv = PV_ALL_ZERO;
                1: pv = PV_ALL_LAST;
                2: pv = PV_IDENTITY;
                default: pv = {$urandom, $urandom};
            endcase
            case ($urandom_range(0, 3))
                0: ins = '0;
                1: ins = LAST_WAY;
                default: ins = WAY_BITS'($urandom);
            endcase
            write_reg(CFG_MODE, PV_W'(p % 2 == 1 ? 1 : 0) ^ PV_W'($urandom_range(0, 3) == 0));
            write_reg(CFG_PROMOTE, pv);
            write_reg(CFG_INSERT, PV_W'(ins));
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_NONE, {$urandom, $urandom});
            for (int k = 0; k < POOL_SIZE; k++)
                tag_pool[k] = IN_TAG_W'($urandom_range(1, 65535));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                no_gaps = ((item / 60) % 5 == 4);
                send_access(pick_tag(), 1'b0, '0);
                item++;
            end
        end
        no_gaps = 1'b0;

        s_valid <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* files.f */
hdl/csrp_pkg.sv
hdl/csrp_tag_store.sv
hdl/csrp_plru_tree.sv
hdl/csrp_seq.sv
hdl/cache_set_replacement_plru_ipv.sv
hdl/csrp_checker.sv
tb/sv/tb_cache_set_replacement_plru_ipv.sv
